// ===== sv/macd_pkg.sv =====
`default_nettype none

package macd_pkg;

    // field and datapath widths
    localparam int PRICE_W    = 32;
    localparam int WEIGHT_W   = 16;
    localparam int AVG_W      = 48;   // Q32.16 fast / slow averages
    localparam int SIG_W      = 50;   // signed Q.16 signal average
    localparam int DIFF_W     = 49;   // signed Q.16 fast - slow
    localparam int DP_W       = 51;   // shared subtractor result
    localparam int LO_W       = 26;   // low chunk of a multiplier operand
    localparam int HI_W       = DP_W - LO_W;
    localparam int MOP_W      = LO_W + 1;
    localparam int PROD_W     = WEIGHT_W + 1 + MOP_W;
    localparam int SUM_W      = 54;
    localparam int FRAC_SHIFT = 16;
    localparam int HI_SHIFT   = LO_W - FRAC_SHIFT;

    localparam int DIFF_OUT_W = 33;
    localparam int SIG_OUT_W  = 33;
    localparam int HIST_W     = 35;
    localparam int FIELDS_W   = DIFF_OUT_W + SIG_OUT_W + HIST_W;
    localparam int TDATA_W    = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - FIELDS_W;

    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL = 2'd2;

    // reset weights, Q0.16
    localparam logic [WEIGHT_W-1:0] FAST_W_RST   = 16'd10080;
    localparam logic [WEIGHT_W-1:0] SLOW_W_RST   = 16'd4856;
    localparam logic [WEIGHT_W-1:0] SIGNAL_W_RST = 16'd13107;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_SUB,
        ALU_MLO,
        ALU_MHI
    } t_alu_op;

    typedef struct packed {
        t_alu_op               op;
        logic [WEIGHT_W-1:0]   weight;
    } t_alu_ctl;

endpackage

`default_nettype wire

// ===== sv/macd_alu.sv =====
`default_nettype none

// Shared subtract / multiply / accumulate unit.
// blend = b + floor(w * (a - b) / 2^16), with the difference multiplied in
// two chunks through one 17x27 signed multiplier.
module macd_alu (
    input  wire logic                                  i_clk,
    input  wire macd_pkg::t_alu_ctl                    i_ctl,
    input  wire logic signed [macd_pkg::DP_W-1:0]      i_a,
    input  wire logic signed [macd_pkg::DP_W-1:0]      i_b,
    output logic signed [macd_pkg::DP_W-1:0]           o_d,
    output logic signed [macd_pkg::SUM_W-1:0]          o_sum
);

    logic signed [macd_pkg::DP_W-1:0]     r_d;
    logic signed [macd_pkg::PROD_W-1:0]   r_plo;
    logic signed [macd_pkg::PROD_W-1:0]   r_phi;

    logic signed [macd_pkg::MOP_W-1:0]    w_mop;
    logic signed [macd_pkg::WEIGHT_W:0]   w_wt;
    logic signed [macd_pkg::PROD_W-1:0]   w_prod;

    // high chunk signed, low chunk unsigned
    assign w_mop = (i_ctl.op == macd_pkg::ALU_MHI)
                 ? macd_pkg::MOP_W'(signed'(r_d[macd_pkg::DP_W-1:macd_pkg::LO_W]))
                 : signed'({1'b0, r_d[macd_pkg::LO_W-1:0]});
    assign w_wt   = signed'({1'b0, i_ctl.weight});
    assign w_prod = w_wt * w_mop;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            macd_pkg::ALU_SUB: r_d   <= i_a - i_b;
            macd_pkg::ALU_MLO: r_plo <= w_prod;
            macd_pkg::ALU_MHI: r_phi <= w_prod;
            macd_pkg::ALU_IDLE: ;
        endcase
    end

    // low product is never negative
    assign o_sum = macd_pkg::SUM_W'(i_b)
                 + (macd_pkg::SUM_W'(r_phi) <<< macd_pkg::HI_SHIFT)
                 + macd_pkg::SUM_W'(r_plo >>> macd_pkg::FRAC_SHIFT);
    assign o_d   = r_d;

endmodule

`default_nettype wire

// ===== sv/macd_indicator_filter.sv =====
`default_nettype none

// MACD filter: fast / slow EMAs of the price, signal EMA of their difference.
// One price at a time: input ready only in ST_IDLE; the shared multiplier and
//   adder run the three blends in turn, four steps each, plus difference and
//   histogram steps, before the result is loaded into the output register.
// Reset (i_rst_n low, synchronous): averages zero, weights to defaults,
//   output register empty, input ready.
module macd_indicator_filter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [macd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [macd_pkg::WEIGHT_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [macd_pkg::PRICE_W-1:0]        s_axis_tdata,  // [31:0] price
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [32:0] difference, [65:33] signal_line, [100:66] histogram, rest zero
    output logic [macd_pkg::TDATA_W-1:0]             m_axis_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_SUB, ST_F_MLO, ST_F_MHI, ST_F_ADD,   // fast average
        ST_S_SUB, ST_S_MLO, ST_S_MHI, ST_S_ADD,   // slow average
        ST_D_SUB,                                 // fast - slow
        ST_G_SUB, ST_G_MLO, ST_G_MHI, ST_G_ADD,   // signal average
        ST_H_SUB,                                 // diff - signal for histogram
        ST_OUT
    } t_state;

    t_state                                   r_state;
    logic [macd_pkg::PRICE_W-1:0]             r_price;
    logic [macd_pkg::AVG_W-1:0]               r_fast;
    logic [macd_pkg::AVG_W-1:0]               r_slow;
    logic signed [macd_pkg::SIG_W-1:0]        r_sig;
    logic signed [macd_pkg::DIFF_W-1:0]       r_diff;
    logic [macd_pkg::WEIGHT_W-1:0]            r_w_fast;
    logic [macd_pkg::WEIGHT_W-1:0]            r_w_slow;
    logic [macd_pkg::WEIGHT_W-1:0]            r_w_sig;
    logic                                     r_m_valid;
    logic [macd_pkg::TDATA_W-1:0]             r_m_data;

    macd_pkg::t_alu_ctl                       w_ctl;
    logic signed [macd_pkg::DP_W-1:0]         w_a;
    logic signed [macd_pkg::DP_W-1:0]         w_b;
    logic signed [macd_pkg::DP_W-1:0]         w_d;
    logic signed [macd_pkg::SUM_W-1:0]        w_sum;

    logic signed [macd_pkg::DP_W-1:0]         w_price_ext;
    logic signed [macd_pkg::DP_W-1:0]         w_fast_ext;
    logic signed [macd_pkg::DP_W-1:0]         w_slow_ext;
    logic signed [macd_pkg::DP_W-1:0]         w_sig_ext;
    logic signed [macd_pkg::DP_W-1:0]         w_diff_ext;
    logic                                     w_out_free;

    // price moves to Q32.16; averages are unsigned, signal and diff signed
    assign w_price_ext = signed'(macd_pkg::DP_W'({r_price, {macd_pkg::FRAC_SHIFT{1'b0}}}));
    assign w_fast_ext  = signed'(macd_pkg::DP_W'(r_fast));
    assign w_slow_ext  = signed'(macd_pkg::DP_W'(r_slow));
    assign w_sig_ext   = macd_pkg::DP_W'(r_sig);
    assign w_diff_ext  = macd_pkg::DP_W'(r_diff);

    // operand and step selection for the shared unit
    always_comb begin
        w_ctl.op     = macd_pkg::ALU_IDLE;
        w_ctl.weight = r_w_fast;
        w_a          = w_price_ext;
        w_b          = w_fast_ext;
        unique case (r_state)
            ST_IDLE, ST_OUT: ;
            ST_F_SUB: w_ctl.op = macd_pkg::ALU_SUB;
            ST_F_MLO: w_ctl.op = macd_pkg::ALU_MLO;
            ST_F_MHI: w_ctl.op = macd_pkg::ALU_MHI;
            ST_F_ADD: ;
            ST_S_SUB: begin
                w_ctl.op = macd_pkg::ALU_SUB;
                w_b      = w_slow_ext;
            end
            ST_S_MLO: begin
                w_ctl.op     = macd_pkg::ALU_MLO;
                w_ctl.weight = r_w_slow;
            end
            ST_S_MHI: begin
                w_ctl.op     = macd_pkg::ALU_MHI;
                w_ctl.weight = r_w_slow;
            end
            ST_S_ADD: w_b = w_slow_ext;
            ST_D_SUB: begin
                w_ctl.op = macd_pkg::ALU_SUB;
                w_a      = w_fast_ext;
                w_b      = w_slow_ext;
            end
            ST_G_SUB: begin
                // unit still holds fast - slow from the previous step
                w_ctl.op = macd_pkg::ALU_SUB;
                w_a      = w_d;
                w_b      = w_sig_ext;
            end
            ST_G_MLO: begin
                w_ctl.op     = macd_pkg::ALU_MLO;
                w_ctl.weight = r_w_sig;
            end
            ST_G_MHI: begin
                w_ctl.op     = macd_pkg::ALU_MHI;
                w_ctl.weight = r_w_sig;
            end
            ST_G_ADD: w_b = w_sig_ext;
            ST_H_SUB: begin
                w_ctl.op = macd_pkg::ALU_SUB;
                w_a      = w_diff_ext;
                w_b      = w_sig_ext;
            end
        endcase
    end

    macd_alu u_alu (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_d   (w_d),
        .o_sum (w_sum)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fast    <= '0;
            r_slow    <= '0;
            r_sig     <= '0;
            r_w_fast  <= macd_pkg::FAST_W_RST;
            r_w_slow  <= macd_pkg::SLOW_W_RST;
            r_w_sig   <= macd_pkg::SIGNAL_W_RST;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    macd_pkg::REG_FAST:   r_w_fast <= i_cfg_data;
                    macd_pkg::REG_SLOW:   r_w_slow <= i_cfg_data;
                    macd_pkg::REG_SIGNAL: r_w_sig  <= i_cfg_data;
                    default: ;
                endcase
            end

            // in ST_OUT the output register is either reloaded or still stalled
            if (r_m_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_price <= s_axis_tdata;
                        r_state <= ST_F_SUB;
                    end
                end
                ST_F_SUB: r_state <= ST_F_MLO;
                ST_F_MLO: r_state <= ST_F_MHI;
                ST_F_MHI: r_state <= ST_F_ADD;
                ST_F_ADD: begin
                    r_fast  <= w_sum[macd_pkg::AVG_W-1:0];
                    r_state <= ST_S_SUB;
                end
                ST_S_SUB: r_state <= ST_S_MLO;
                ST_S_MLO: r_state <= ST_S_MHI;
                ST_S_MHI: r_state <= ST_S_ADD;
                ST_S_ADD: begin
                    r_slow  <= w_sum[macd_pkg::AVG_W-1:0];
                    r_state <= ST_D_SUB;
                end
                ST_D_SUB: r_state <= ST_G_SUB;
                ST_G_SUB: begin
                    r_diff  <= w_d[macd_pkg::DIFF_W-1:0];
                    r_state <= ST_G_MLO;
                end
                ST_G_MLO: r_state <= ST_G_MHI;
                ST_G_MHI: r_state <= ST_G_ADD;
                ST_G_ADD: begin
                    r_sig   <= w_sum[macd_pkg::SIG_W-1:0];
                    r_state <= ST_H_SUB;
                end
                ST_H_SUB: r_state <= ST_OUT;
                ST_OUT: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_m_data  <= {
                            {macd_pkg::PAD_W{1'b0}},
                            w_d[macd_pkg::HIST_W+macd_pkg::FRAC_SHIFT-2:
                                macd_pkg::FRAC_SHIFT-1],           // 2*(d-s) >> 16
                            r_sig[macd_pkg::SIG_OUT_W+macd_pkg::FRAC_SHIFT-1:
                                  macd_pkg::FRAC_SHIFT],
                            r_diff[macd_pkg::DIFF_OUT_W+macd_pkg::FRAC_SHIFT-1:
                                   macd_pkg::FRAC_SHIFT]
                        };
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== sv/macd_checker.sv =====
`default_nettype none

module macd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [macd_pkg::TDATA_W-1:0]        m_axis_tdata
);

    logic w_s_xfer;
    assign w_s_xfer = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer |=> !s_axis_tready)
        else $error("input ready right after transfer");

    a_busy_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer |-> ##4 !s_axis_tready)
        else $error("sequencer finished too early");

    // a result cannot appear the cycle after its input
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer |=> !$rose(m_axis_tvalid))
        else $error("result too early");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

bind macd_indicator_filter macd_checker u_macd_checker (.*);

`default_nettype wire

// ===== tb/tb_macd_indicator_filter.sv =====
`default_nettype none

module tb_macd_indicator_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import macd_pkg::*;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // idle margin after the last pending result before weights change or the run ends
    localparam int DRAIN_CYCLES = 24;
    localparam int RUN_LIMIT    = 5_000_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 240;

    // one expected result, fields at their port widths
    typedef struct {
        logic signed [DIFF_OUT_W-1:0] difference;
        logic signed [SIG_OUT_W-1:0]  signal_line;
        logic signed [HIST_W-1:0]     histogram;
    } macd_out_t;

    // Tracks the three averages at 16 fraction bits and queues the result
    // each accepted price must produce.
    class macd_scoreboard;
        logic [WEIGHT_W-1:0] fast_w;
        logic [WEIGHT_W-1:0] slow_w;
        logic [WEIGHT_W-1:0] signal_w;
        logic signed [63:0]  fast_avg;
        logic signed [63:0]  slow_avg;
        logic signed [63:0]  signal_avg;
        macd_out_t           expected_q[$];
        int                  errors;

        function new();
            fast_w     = FAST_W_RST;
            slow_w     = SLOW_W_RST;
            signal_w   = SIGNAL_W_RST;
            fast_avg   = '0;
            slow_avg   = '0;
            signal_avg = '0;
            errors     = 0;
        endfunction

        function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] value);
            case (idx)
                REG_FAST:   fast_w   = value;
                REG_SLOW:   slow_w   = value;
                REG_SIGNAL: signal_w = value;
                default: ;  // unknown index: ignored
            endcase
        endfunction

        // floor((w*a + (1-w)*b)), w in Q0.16; arithmetic shift floors
        function logic signed [63:0] blend(logic [WEIGHT_W-1:0] w,
                                           logic signed [63:0] a,
                                           logic signed [63:0] b);
            logic signed [81:0] wa;
            logic signed [81:0] wb;
            logic signed [81:0] mix;
            wa  = $signed({66'd0, w});
            wb  = 82'sd65536 - wa;
            mix = wa * a + wb * b;
            return 64'(mix >>> FRAC_SHIFT);
        endfunction

        function void note_price(logic [PRICE_W-1:0] price);
            logic signed [63:0] price_q;
            logic signed [63:0] diff_q;
            logic signed [63:0] hist_q;
            macd_out_t          prediction;
            price_q    = $signed({16'd0, price, 16'd0});   // Q32.16
            fast_avg   = blend(fast_w, price_q, fast_avg);
            slow_avg   = blend(slow_w, price_q, slow_avg);
            diff_q     = fast_avg - slow_avg;
            signal_avg = blend(signal_w, diff_q, signal_avg);
            hist_q     = (diff_q - signal_avg) <<< 1;
            // drop 16 fraction bits toward minus infinity
            prediction.difference  = DIFF_OUT_W'(diff_q >>> FRAC_SHIFT);
            prediction.signal_line = SIG_OUT_W'(signal_avg >>> FRAC_SHIFT);
            prediction.histogram   = HIST_W'(hist_q >>> FRAC_SHIFT);
            expected_q.push_back(prediction);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_error(string msg);
            if (errors < 50)
                $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [TDATA_W-1:0] tdata);
            macd_out_t                    want;
            logic signed [DIFF_OUT_W-1:0] got_diff;
            logic signed [SIG_OUT_W-1:0]  got_sig;
            logic signed [HIST_W-1:0]     got_hist;
            if (expected_q.size() == 0) begin
                report_error($sformatf("result transfer with none pending: %h", tdata));
                return;
            end
            want     = expected_q.pop_front();
            got_diff = tdata[DIFF_OUT_W-1:0];
            got_sig  = tdata[DIFF_OUT_W+SIG_OUT_W-1:DIFF_OUT_W];
            got_hist = tdata[FIELDS_W-1:DIFF_OUT_W+SIG_OUT_W];
            if (got_diff !== want.difference)
                report_error($sformatf("difference got %0d want %0d",
                                       got_diff, want.difference));
            if (got_sig !== want.signal_line)
                report_error($sformatf("signal_line got %0d want %0d",
                                       got_sig, want.signal_line));
            if (got_hist !== want.histogram)
                report_error($sformatf("histogram got %0d want %0d",
                                       got_hist, want.histogram));
            if (tdata[TDATA_W-1:FIELDS_W] !== '0)
                report_error($sformatf("tdata padding not zero: %h", tdata));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [WEIGHT_W-1:0]   i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PRICE_W-1:0]    s_axis_tdata  = '0;     // [31:0] price
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [32:0] difference, [65:33] signal_line, [100:66] histogram, rest zero
    logic [TDATA_W-1:0]    m_axis_tdata;

    macd_scoreboard sb = new();

    int                    cycle_count   = 0;
    logic [15:0]           ready_pattern = 16'hFFFF;
    int                    pattern_age   = 0;
    logic [PRICE_W-1:0]    price_level   = 32'h0064_0000;

    macd_indicator_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver: rotate a 16-bit ready pattern, reloaded at random intervals
    // with one of: always ready, random, mostly ready, mostly stalled.
    always @(posedge i_clk) begin
        m_axis_tready <= ready_pattern[0];
        if (pattern_age == 0) begin
            pattern_age <= $urandom_range(32, 160);
            case ($urandom_range(0, 4))
                0, 1:    ready_pattern <= 16'hFFFF;
                2:       ready_pattern <= 16'($urandom);
                3:       ready_pattern <= 16'($urandom) | 16'($urandom);
                default: ready_pattern <= 16'($urandom) & 16'($urandom) & 16'($urandom);
            endcase
        end else begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // result monitor: every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Mostly a random walk (realistic ticks), plus full-range values,
    // both extremes and sudden jumps.
    function automatic logic [PRICE_W-1:0] next_price();
        longint nxt;
        case ($urandom_range(0, 9))
            0, 1: price_level = $urandom;
            2:    price_level = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            3:    price_level = $urandom & ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h00FF_FFFF);
            default: begin
                nxt = longint'(price_level) + longint'($urandom_range(0, 2097152)) - 1048576;
                if (nxt < 0)
                    nxt = 0;
                if (nxt > 64'hFFFF_FFFF)
                    nxt = 64'hFFFF_FFFF;
                price_level = nxt[31:0];
            end
        endcase
        return price_level;
    endfunction

    // Send prices in bursts of random length with random gaps between them;
    // valid stays high across a burst. Gaps land on every phase of the
    // block's step schedule.
    task automatic drive_prices(input logic [PRICE_W-1:0] prices[$]);
        int burst;
        int gap;
        burst = 0;
        foreach (prices[k]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= prices[k];
            do @(posedge i_clk); while (!s_axis_tready);
            sb.note_price(prices[k]);
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for the block to drain, then write the selected weights
    // (bit 0 fast, 1 slow, 2 signal), optionally followed by a junk write
    // to the unused index.
    task automatic set_weights(input logic [WEIGHT_W-1:0] fast_val,
                               input logic [WEIGHT_W-1:0] slow_val,
                               input logic [WEIGHT_W-1:0] signal_val,
                               input bit [2:0]            which,
                               input bit                  junk);
        logic [WEIGHT_W-1:0] junk_val;
        junk_val = 16'($urandom);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            if ((r < 3 && which[r]) || (r == 3 && junk)) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(r);
                case (r)
                    0:       i_cfg_data <= fast_val;
                    1:       i_cfg_data <= slow_val;
                    2:       i_cfg_data <= signal_val;
                    default: i_cfg_data <= junk_val;
                endcase
                case (r)
                    0:       sb.set_weight(REG_FAST, fast_val);
                    1:       sb.set_weight(REG_SLOW, slow_val);
                    2:       sb.set_weight(REG_SIGNAL, signal_val);
                    default: sb.set_weight(REG_UNUSED, junk_val);
                endcase
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 6))
            0:       return 16'd0;       // average frozen
            1:       return 16'hFFFF;    // average follows input almost fully
            2:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [PRICE_W-1:0] prices[$];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults from reset: zero, both extremes, smallest step, mid-scale
        prices = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0,
                   32'h8000_0000, 32'h7FFF_FFFF};
        drive_prices(prices);

        // fast tracks price, slow frozen at its value: largest positive gap;
        // the junk write must leave every weight alone
        set_weights(16'hFFFF, 16'h0000, 16'hFFFF, 3'b111, 1'b1);
        prices = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        drive_prices(prices);

        // the reverse: large negative gap with fraction bits (floor of
        // negative values); signal weight zero keeps the signal average unchanged
        set_weights(16'h0000, 16'hFFFF, 16'h0000, 3'b111, 1'b0);
        prices = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0001};
        drive_prices(prices);

        // equal weights, signal barely moving
        set_weights(16'hFFFF, 16'hFFFF, 16'h0001, 3'b111, 1'b1);
        prices = '{32'hFFFF_FFFF, 32'h0, 32'h1234_5678};
        drive_prices(prices);

        // random phases: new weights each time, sometimes only some registers
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_weights(pick_weight(), pick_weight(), pick_weight(),
                        (p == 0) ? 3'b111 : 3'($urandom_range(1, 7)),
                        $urandom_range(0, 2) == 0);
            prices = {};
            for (int n = 0; n < PHASE_ITEMS; n++)
                prices.push_back(next_price());
            drive_prices(prices);
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== macd_indicator_filter.f =====
sv/macd_pkg.sv
sv/macd_alu.sv
sv/macd_indicator_filter.sv
sv/macd_checker.sv
tb/tb_macd_indicator_filter.sv
